// ----- rtl/core/fesp_pkg.sv -----
// Package for the flash erase sector planner: word types, sizes and sector map.
`default_nettype none

package fesp_pkg;

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaskW  = 8;
  localparam int unsigned CountW = 4;

  // Sector layout
  localparam int unsigned SectorCountDefault = 8;
  localparam int unsigned SectorCountMax     = 16;
  localparam int unsigned SectorIdxW         = $clog2(SectorCountMax);
  localparam int unsigned SmallSectors       = 4;
  localparam logic [AddrW-1:0] SizeSmall     = 32'h0000_4000;
  localparam logic [AddrW-1:0] SizeMedium    = 32'h0001_0000;
  localparam logic [AddrW-1:0] SizeLarge     = 32'h0002_0000;
  localparam logic [AddrW-1:0] BaseReset     = 32'h0800_0000;

  // Input word: one byte of a program request
  typedef struct packed {
    logic [AddrW-1:0] dest_addr;
    logic [ByteW-1:0] current_byte;
    logic [ByteW-1:0] new_byte;
    logic             first_byte;
    logic             last_byte;
  } fesp_in_t;

  // Result word: erase plan of one request
  typedef struct packed {
    logic [MaskW-1:0]  erase_sel;
    logic [CountW-1:0] erase_count;
    logic              range_error;
  } fesp_out_t;

  // Offset from the flash base of the first byte past sector idx
  function automatic logic [AddrW-1:0] sector_end(input int unsigned idx);
    logic [AddrW-1:0] res;
    if (idx < SmallSectors) begin
      res = AddrW'(idx + 1) * SizeSmall;
    end else if (idx == SmallSectors) begin
      res = AddrW'(SmallSectors) * SizeSmall + SizeMedium;
    end else begin
      res = AddrW'(SmallSectors) * SizeSmall + SizeMedium
          + AddrW'(idx - SmallSectors) * SizeLarge;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/flash_erase_sector_planner.sv -----
// Flash erase sector planner: decodes request bytes to sectors and builds the erase plan.
//
// Usage: program request bytes enter on the in channel (valid/ready), one word
// per byte with its destination address, the byte now in flash and the new
// byte. first_byte clears the running plan, last_byte closes the request and
// yields one result word on the out channel (valid/ready): the erase mask,
// its population count and a range error flag. Words without last_byte give
// no result. The user writes the flash base through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
// Throughput: one word per cycle while in_ready_o is high. A word accepted
// into the input register is decoded from there; the result of a closing
// word is registered in the output register, which drives out_valid_o.
// The decode is a bank of constant compares on the offset from the base; the
// running mask and error flag are one register each, updated whenever the
// input register advances. Reset clears the pipeline, the running plan and
// sets the base to its default. When the receiver stalls, the held result
// keeps the input stage moving for bytes that close no request; a closing
// byte waits in the input register and in_ready_o drops until the output
// register frees.
`default_nettype none

module flash_erase_sector_planner #(
  parameter int unsigned SectorCount = fesp_pkg::SectorCountDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire fesp_pkg::fesp_in_t        in_word_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output fesp_pkg::fesp_out_t            out_word_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [fesp_pkg::AddrW-1:0] cfg_wdata_i
);
  import fesp_pkg::*;

  logic [AddrW-1:0] base_q;
  fesp_in_t         s1_word_q;
  logic             s1_valid_q;
  logic [MaskW-1:0] mask_q, mask_d;
  logic             err_q, err_d;
  fesp_out_t        out_q, out_d;
  logic             out_valid_q;

  logic                      out_free;
  logic                      s1_adv;
  logic [AddrW-1:0]          offset;
  logic                      below;
  logic [SectorCountMax-1:0] past;
  logic                      in_range;
  logic                      needs_erase;
  logic [MaskW-1:0]          hit;
  logic [CountW-1:0]         pop;

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_word_q.last_byte || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Flash base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  // Sector decode: compare the offset against each sector's end
  always_comb begin
    offset      = s1_word_q.dest_addr - base_q;
    below       = s1_word_q.dest_addr < base_q;
    for (int unsigned i = 0; i < SectorCountMax; i++) begin
      past[i] = offset >= sector_end(i);
    end
    in_range    = !below && !past[SectorIdxW'(SectorCount - 1)];
    needs_erase = (s1_word_q.current_byte & s1_word_q.new_byte) != s1_word_q.new_byte;
    for (int unsigned i = 0; i < MaskW; i++) begin
      hit[i] = (i < SectorCount) && in_range && needs_erase && !past[i]
             && ((i == 0) || past[(i == 0) ? 0 : i - 1]);
    end
  end

  // Plan accumulation and result
  always_comb begin
    mask_d = (s1_word_q.first_byte ? '0 : mask_q) | hit;
    err_d  = (s1_word_q.first_byte ? 1'b0 : err_q) | !in_range;
    pop    = '0;
    for (int unsigned i = 0; i < MaskW; i++) begin
      pop = pop + CountW'(mask_d[i]);
    end
    out_d.erase_sel   = mask_d;
    out_d.erase_count = pop;
    out_d.range_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      err_q  <= 1'b0;
    end else if (s1_adv) begin
      mask_q <= s1_word_q.last_byte ? '0 : mask_d;
      err_q  <= s1_word_q.last_byte ? 1'b0 : err_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_word_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_word_q.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/fesp_checker.sv -----
// Port checker for the flash erase sector planner and its bind.
`default_nettype none

module fesp_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire fesp_pkg::fesp_out_t out_word_o
);
  import fesp_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");

  // Count matches the mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.erase_count == CountW'($countones(out_word_o.erase_sel)))
    else $error("erase count does not match mask");

  // With the output register empty the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // The input side stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !out_ready_i)
    else $error("input stalled while the result side was ready");

endmodule

bind flash_erase_sector_planner fesp_checker u_fesp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
